### hdl/cad_pkg.sv
// ----------------------------------------------------------------------------
// cad_pkg
// Shared types and constants of the channel averaging and distance block.
// ----------------------------------------------------------------------------
package cad_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned SUM_W    = 18;
  localparam int unsigned LEVEL_W  = 10;
  localparam int unsigned NUM_W    = 16;
  localparam int unsigned DIST_W   = 7;
  localparam int unsigned CHAR_W   = 6;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_SCALE  = 2'd0,
    CFG_LEVEL_OFFSET = 2'd1,
    CFG_DIST_NUM     = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  localparam logic [LEVEL_W-1:0] SCALE_RST  = 10'd330;
  localparam logic [LEVEL_W-1:0] OFFSET_RST = 10'd13;
  localparam logic [NUM_W-1:0]   NUM_RST    = 16'd2408;

  // distance clamping and digit coding
  localparam logic [DIST_W-1:0] DIST_LIMIT   = 7'd100;
  localparam logic [DIST_W-1:0] DIST_OOR     = 7'd99;
  localparam logic [DIST_W-1:0] CLAMP_BASE   = 7'd90;
  localparam logic [CHAR_W-1:0] ASCII_ZERO   = 6'h30;
  localparam logic [LEVEL_W-1:0] DECIMAL_BASE = 10'd10;

  // input transaction
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]   channel;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [CHAN_W-1:0]   result_channel;
    logic [SAMPLE_W-1:0] average;
    logic [LEVEL_W-1:0]  level_centivolts;
    logic [DIST_W-1:0]   distance;
    logic [CHAR_W-1:0]   tens_char;
    logic [CHAR_W-1:0]   units_char;
    logic                out_of_range;
  } out_t;

  // completed block handed from front to back
  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [SUM_W-1:0]  sum;
  } job_t;

  // configuration values seen by the back end
  typedef struct packed {
    logic [LEVEL_W-1:0] level_scale;
    logic [LEVEL_W-1:0] level_offset;
    logic [NUM_W-1:0]   distance_numerator;
  } cfg_t;

endpackage

### hdl/cad_front.sv
// ----------------------------------------------------------------------------
// cad_front
// Per-channel accumulation; emits a job when a channel completes its block.
// ----------------------------------------------------------------------------
module cad_front
  import cad_pkg::*;
#(
  parameter int unsigned SAMPLES  = 50,
  parameter int unsigned CHANNELS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic accept_i,
  input  in_t  item_i,
  output logic push_o,
  output job_t job_o
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(SAMPLES + 1);

  logic [SUM_W-1:0] sum_q [CHANNELS];
  logic [CNT_W-1:0] cnt_q [CHANNELS];

  logic             chan_ok;
  logic [IDX_W-1:0] idx;
  logic [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0] cnt_next;
  logic             block_done;

  // channel decode and running totals
  assign chan_ok    = ({1'b0, item_i.channel} < (CHAN_W + 1)'(CHANNELS));
  assign idx        = IDX_W'(item_i.channel);
  assign sum_next   = sum_q[idx] + SUM_W'(item_i.sample);
  assign cnt_next   = cnt_q[idx] + CNT_W'(1);
  assign block_done = (cnt_next == CNT_W'(SAMPLES));

  // job towards the queue
  assign push_o      = accept_i && chan_ok && block_done;
  assign job_o.channel = item_i.channel;
  assign job_o.sum     = sum_next;

  // accumulator update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else if (accept_i && chan_ok) begin
      if (block_done) begin
        sum_q[idx] <= '0;
        cnt_q[idx] <= '0;
      end else begin
        sum_q[idx] <= sum_next;
        cnt_q[idx] <= cnt_next;
      end
    end
  end

endmodule

### hdl/cad_fifo.sv
// ----------------------------------------------------------------------------
// cad_fifo
// Two-entry job queue between the accumulating front and the back end.
// ----------------------------------------------------------------------------
module cad_fifo
  import cad_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o,
  output logic full_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  job_t               mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]     count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (PTR_W + 1)'(DEPTH));
  assign job_o   = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (PTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (PTR_W + 1)'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("job queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("job queue read while empty");
`endif

endmodule

### hdl/cad_div.sv
// ----------------------------------------------------------------------------
// cad_div
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cad_div
  import cad_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SUM_W-1:0]   dividend_i,
  input  logic [LEVEL_W-1:0] divisor_i,
  output logic               done_o,
  output logic [SUM_W-1:0]   quotient_o
);

  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  logic               busy_q, done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [SUM_W-1:0]   quo_q;
  logic [LEVEL_W-1:0] rem_q, divisor_q;
  logic [LEVEL_W:0]   trial;
  logic               fits;
  logic [LEVEL_W:0]   diff;

  // one trial subtraction per step
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign fits  = (trial >= {1'b0, divisor_q});
  assign diff  = trial - {1'b0, divisor_q};

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q     <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[SUM_W-2:0], fits};
      rem_q <= fits ? diff[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
    end
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(SUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");
`endif

endmodule

### hdl/cad_back.sv
// ----------------------------------------------------------------------------
// cad_back
// Averages a completed block, scales it to centivolts, linearises distance
// and holds the result transaction in an output register.
// ----------------------------------------------------------------------------
module cad_back
  import cad_pkg::*;
#(
  parameter int unsigned SAMPLES = 50
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic empty_i,
  input  job_t job_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_AVG  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_DIST = 3'd4;
  localparam logic [2:0] ST_MOD  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;
  localparam logic [2:0] ST_REM  = 3'd7;

  localparam int unsigned PROD_W = SAMPLE_W + LEVEL_W;
  localparam int unsigned TENS_W = 15;

  // block average by reciprocal of SAMPLES, exact over the whole sum range
  localparam int unsigned AVG_SHIFT  = SUM_W + $clog2(SAMPLES);
  localparam int unsigned RECIP_W    = SUM_W + 1;
  localparam int unsigned AVG_PROD_W = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

  // quotient by ten of a 16-bit raw distance by reciprocal
  localparam int unsigned DEC_SHIFT   = NUM_W + 4;
  localparam int unsigned DEC_RECIP_W = NUM_W + 1;
  localparam int unsigned DEC_PROD_W  = NUM_W + DEC_RECIP_W;
  localparam int unsigned DEC_QUO_W   = NUM_W - 3;
  localparam logic [DEC_RECIP_W-1:0] DEC_RECIP =
    DEC_RECIP_W'(((64'd1 << DEC_SHIFT) + 64'(DECIMAL_BASE) - 64'd1) / 64'(DECIMAL_BASE));

  logic [2:0]           state_q, state_d;
  logic [CHAN_W-1:0]    chan_q;
  logic [SUM_W-1:0]     sum_q;
  logic [SAMPLE_W-1:0]  avg_q;
  logic [LEVEL_W-1:0]   level_q;
  logic [DIST_W-1:0]    dist_q;
  logic [DEC_QUO_W-1:0] dec_quo_q;
  logic                 oor_q;
  logic                 out_valid_q;
  out_t                 out_q;

  logic                 div_start;
  logic [SUM_W-1:0]     div_dividend;
  logic [LEVEL_W-1:0]   div_divisor;
  logic                 div_done;
  logic [SUM_W-1:0]     div_quo;

  logic [AVG_PROD_W-1:0] avg_prod;
  logic [PROD_W-1:0]     prod;
  logic [DEC_PROD_W-1:0] dec_prod;
  logic [NUM_W-1:0]      raw_units;
  logic                  out_free;
  logic [TENS_W-1:0]     tens_scaled;
  logic [3:0]            tens;
  logic [DIST_W-1:0]     units;

  cad_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // block average
  assign avg_prod = AVG_PROD_W'(sum_q) * AVG_PROD_W'(AVG_RECIP);

  // level scaling product
  assign prod = PROD_W'(avg_q) * PROD_W'(cfg_i.level_scale);

  // units digit of a raw distance of 100 or more, via a registered quotient by ten
  assign dec_prod  = DEC_PROD_W'(div_quo[NUM_W-1:0]) * DEC_PROD_W'(DEC_RECIP);
  assign raw_units = div_quo[NUM_W-1:0]
                     - NUM_W'(dec_quo_q) * NUM_W'(DECIMAL_BASE);

  // decimal digits of a two-digit distance: tens by reciprocal 205/2048
  assign tens_scaled = TENS_W'(dist_q) * TENS_W'(205);
  assign tens        = tens_scaled[14:11];
  assign units       = dist_q - DIST_W'(tens) * DIST_W'(10);

  assign out_free    = !out_valid_q || !out_stall_i;
  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // distance reciprocal launch
  assign div_start    = (state_q == ST_CMP) && (level_q > cfg_i.level_offset);
  assign div_dividend = SUM_W'(cfg_i.distance_numerator);
  assign div_divisor  = level_q - cfg_i.level_offset;

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (!empty_i) state_d = ST_AVG;
      ST_AVG:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_CMP;
      ST_CMP:  state_d = (level_q > cfg_i.level_offset) ? ST_DIST : ST_OUT;
      ST_DIST: begin
        if (div_done) begin
          state_d = (div_quo >= SUM_W'(DIST_LIMIT)) ? ST_MOD : ST_OUT;
        end
      end
      ST_MOD:  state_d = ST_REM;
      ST_REM:  state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      chan_q <= job_i.channel;
      sum_q  <= job_i.sum;
    end
    if (state_q == ST_AVG) begin
      avg_q <= avg_prod[AVG_SHIFT +: SAMPLE_W];
    end
    if (state_q == ST_MUL) begin
      level_q <= prod[PROD_W-1:SAMPLE_W];
    end
    if (state_q == ST_CMP) begin
      oor_q  <= !(level_q > cfg_i.level_offset);
      dist_q <= DIST_OOR;
    end
    if (state_q == ST_DIST && div_done) begin
      dist_q <= div_quo[DIST_W-1:0];
    end
    if (state_q == ST_MOD) begin
      dec_quo_q <= dec_prod[DEC_SHIFT +: DEC_QUO_W];
    end
    if (state_q == ST_REM) begin
      dist_q <= CLAMP_BASE + DIST_W'(raw_units[3:0]);
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      out_q.result_channel   <= chan_q;
      out_q.average          <= avg_q;
      out_q.level_centivolts <= level_q;
      out_q.distance         <= dist_q;
      out_q.tens_char        <= ASCII_ZERO + CHAR_W'(tens);
      out_q.units_char       <= ASCII_ZERO + CHAR_W'(units);
      out_q.out_of_range     <= oor_q;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_oor_distance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.out_of_range) |-> (out_q.distance == DIST_OOR))
    else $error("out-of-range result without forced distance");

  a_pop_starts_avg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == ST_AVG))
    else $error("job taken without starting the average");
`endif

endmodule

### hdl/channel_average_distance.sv
// ----------------------------------------------------------------------------
// channel_average_distance
// Block averaging and distance linearisation for tagged ADC channels.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle whenever the two-entry job queue has room;
// each completes its channel's running sum in that same cycle. When a channel
// reaches SAMPLES samples, its block sum is queued and the back end turns it
// into one result transaction. The average and the decimal digits come from
// constant reciprocal multiplications; the distance reciprocal runs on a
// bit-serial divider. A result runs through AVG, MUL, CMP, DIST (divider) if
// the level is above the offset, MOD and REM for a clamped distance, and OUT,
// held while the output stalls. Samples are stalled only when two completed
// blocks wait behind the one being worked on. Sample channels at or above
// CHANNELS are dropped. Configuration registers are written by index on
// cfg_we_i while no block is in the back end, kept by the user, not enforced.
// ----------------------------------------------------------------------------
module channel_average_distance
  import cad_pkg::*;
#(
  parameter int unsigned SAMPLES  = 50,
  parameter int unsigned CHANNELS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q;
  logic in_accept;
  logic push;
  job_t push_job;
  logic pop;
  job_t pop_job;
  logic q_empty, q_full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_scale        <= SCALE_RST;
      cfg_q.level_offset       <= OFFSET_RST;
      cfg_q.distance_numerator <= NUM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LEVEL_SCALE:  cfg_q.level_scale        <= cfg_data_i[LEVEL_W-1:0];
        CFG_LEVEL_OFFSET: cfg_q.level_offset       <= cfg_data_i[LEVEL_W-1:0];
        CFG_DIST_NUM:     cfg_q.distance_numerator <= cfg_data_i[NUM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input handshake
  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !q_full;

  cad_front #(
    .SAMPLES  (SAMPLES),
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_i),
    .push_o   (push),
    .job_o    (push_job)
  );

  cad_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (pop_job),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  cad_back #(
    .SAMPLES (SAMPLES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (q_empty),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the channel averaging and distance block. A table
// of whole sample blocks covers the register extremes and the clamping and
// out-of-range cases, then randomly shaped blocks on interleaved channels run
// under changing register settings, idling on both sides and a long output
// hold-off. Every result is compared with a table row or a local prediction.
// ----------------------------------------------------------------------------
module testbench;
  import cad_pkg::*;

  localparam int unsigned SAMPLES_PER_BLOCK = 50;
  localparam int unsigned NUM_CHANNELS      = 8;
  localparam int unsigned DRAIN_CYCLES      = 100;
  localparam int unsigned HOLD_CYCLES       = 1000;
  localparam int unsigned WATCHDOG_LIMIT    = 5000;
  localparam int unsigned SEGMENTS          = 6;
  localparam int unsigned SEG_SAMPLES       = 160;
  localparam int unsigned PRESSURE_SEG      = 4;
  localparam int unsigned PRESSURE_BLOCKS   = 5;

  // one directed row: a whole block of identical samples on one channel
  typedef struct packed {
    logic [LEVEL_W-1:0]  scale;
    logic [LEVEL_W-1:0]  offset;
    logic [NUM_W-1:0]    numerator;
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample;
    logic                typed;
    logic [SAMPLE_W-1:0] average;
    logic [LEVEL_W-1:0]  level;
    logic [DIST_W-1:0]   distance;
    logic [CHAR_W-1:0]   tens;
    logic [CHAR_W-1:0]   units;
    logic                oor;
  } block_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  in_t                   sample_data = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  out_t                  result_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = CFG_LEVEL_SCALE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predicted registers and per-channel accumulators
  logic [LEVEL_W-1:0]    scale_reg = SCALE_RST;
  logic [LEVEL_W-1:0]    offset_reg = OFFSET_RST;
  logic [NUM_W-1:0]      num_reg = NUM_RST;
  logic [SUM_W-1:0]      block_sum [NUM_CHANNELS];
  logic [6:0]            block_count [NUM_CHANNELS];

  out_t                  expected_results [$];
  out_t                  typed_result [NUM_CHANNELS];
  bit                    typed_valid [NUM_CHANNELS];

  // random block shaping per channel
  int                    gen_left [NUM_CHANNELS];
  int                    gen_base [NUM_CHANNELS];
  int                    gen_spread [NUM_CHANNELS];

  int unsigned           tx_idle_pct = 0;
  int unsigned           rx_idle_pct = 0;
  int unsigned           hold_requests = 0;
  int unsigned           hold_served = 0;
  int unsigned           hold_left = 0;
  int unsigned           failures = 0;
  int unsigned           samples_accepted = 0;
  int unsigned           results_checked = 0;
  int unsigned           settings_applied = 0;
  int unsigned           quiet_cycles = 0;

  block_row_t            directed_blocks [13];

  channel_average_distance #(
    .SAMPLES  (SAMPLES_PER_BLOCK),
    .CHANNELS (NUM_CHANNELS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_valid),
    .in_stall_o  (sample_stall),
    .in_i        (sample_data),
    .out_valid_o (result_valid),
    .out_stall_i (result_stall),
    .out_o       (result_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // accumulate one sample; returns 1 with the block result when a block closes
  function automatic bit accumulate_sample(input in_t item, output out_t res);
    int unsigned ch;
    int unsigned avg;
    int unsigned lvl;
    int unsigned raw;
    res = '0;
    ch  = item.channel;
    if (ch >= NUM_CHANNELS) return 1'b0;
    block_sum[ch]   = block_sum[ch] + item.sample;
    block_count[ch] = block_count[ch] + 1'b1;
    if (block_count[ch] < SAMPLES_PER_BLOCK) return 1'b0;
    avg             = block_sum[ch] / SAMPLES_PER_BLOCK;
    block_sum[ch]   = '0;
    block_count[ch] = '0;
    lvl = (avg * scale_reg) >> SAMPLE_W;
    res.result_channel   = CHAN_W'(ch);
    res.average          = SAMPLE_W'(avg);
    res.level_centivolts = LEVEL_W'(lvl);
    // level at or below the offset has no meaningful reciprocal
    if (lvl <= offset_reg) begin
      res.out_of_range = 1'b1;
      res.distance     = DIST_OOR;
    end else begin
      raw = num_reg / (lvl - offset_reg);
      if (raw >= DIST_LIMIT) raw = CLAMP_BASE + raw % 10;
      res.distance = DIST_W'(raw);
    end
    res.tens_char  = ASCII_ZERO + CHAR_W'(res.distance / 10);
    res.units_char = ASCII_ZERO + CHAR_W'(res.distance % 10);
    return 1'b1;
  endfunction

  // random sample on a channel: each channel runs blocks around a base level
  function automatic in_t next_random_sample(input int ch);
    in_t item;
    int  value;
    if (gen_left[ch] == 0) begin
      gen_left[ch] = SAMPLES_PER_BLOCK;
      case ($urandom_range(5))
        0:       gen_base[ch] = $urandom_range(300);
        1:       gen_base[ch] = $urandom_range(3900, 4095);
        default: gen_base[ch] = $urandom_range(4095);
      endcase
      case ($urandom_range(2))
        0:       gen_spread[ch] = 0;
        1:       gen_spread[ch] = 16;
        default: gen_spread[ch] = 4095;
      endcase
    end
    gen_left[ch]--;
    value = gen_base[ch] + int'($urandom_range(2 * gen_spread[ch])) - gen_spread[ch];
    if (value < 0) value = 0;
    if (value > 4095) value = 4095;
    item.channel = CHAN_W'(ch);
    item.sample  = SAMPLE_W'(value);
    return item;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // offer one sample transaction, with random idle cycles ahead of it
  task automatic send_sample(input in_t item);
    while ($urandom_range(99) < tx_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_valid <= 1'b1;
    sample_data  <= item;
    @(posedge clk_i);
    while (sample_stall) @(posedge clk_i);
  endtask

  // let every outstanding result arrive, then let the back end settle
  task automatic wait_drained();
    sample_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LEVEL_SCALE:  scale_reg  = data[LEVEL_W-1:0];
      CFG_LEVEL_OFFSET: offset_reg = data[LEVEL_W-1:0];
      CFG_DIST_NUM:     num_reg    = data[NUM_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // full register setting; upper data bits and the spare index carry noise
  task automatic apply_setting(input logic [LEVEL_W-1:0] scale,
                               input logic [LEVEL_W-1:0] offset,
                               input logic [NUM_W-1:0] numerator);
    write_reg(CFG_LEVEL_SCALE, {6'($urandom), scale});
    write_reg(CFG_LEVEL_OFFSET, {6'($urandom), offset});
    write_reg(CFG_DIST_NUM, numerator);
    write_reg(CFG_UNUSED, 16'($urandom));
    settings_applied++;
  endtask

  // result stall: random idling, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served  <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // prediction on accepted samples, checking of accepted results, watchdog
  always @(posedge clk_i) begin : monitor
    out_t predicted;
    out_t want;
    bit   moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (sample_valid && !sample_stall) begin
        moved = 1'b1;
        samples_accepted++;
        if (accumulate_sample(sample_data, predicted)) begin
          if (typed_valid[predicted.result_channel]) begin
            expected_results.push_back(typed_result[predicted.result_channel]);
            typed_valid[predicted.result_channel] = 1'b0;
          end else begin
            expected_results.push_back(predicted);
          end
        end
      end
      if (result_valid && !result_stall) begin
        moved = 1'b1;
        results_checked++;
        if (expected_results.size() == 0) begin
          $error("result on channel %0d with no expectation waiting",
                 result_data.result_channel);
          failures++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_channel", want.result_channel, result_data.result_channel);
          check_field("average", want.average, result_data.average);
          check_field("level_centivolts", want.level_centivolts,
                      result_data.level_centivolts);
          check_field("distance", want.distance, result_data.distance);
          check_field("tens_char", want.tens_char, result_data.tens_char);
          check_field("units_char", want.units_char, result_data.units_char);
          check_field("out_of_range", want.out_of_range, result_data.out_of_range);
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("** channel_average_distance: FAILED **");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int          pressure_ch;
    block_row_t  row;
    in_t         item;

    for (int c = 0; c < NUM_CHANNELS; c++) begin
      block_sum[c]   = '0;
      block_count[c] = '0;
      typed_valid[c] = 1'b0;
      gen_left[c]    = 0;
      gen_base[c]    = 0;
      gen_spread[c]  = 0;
    end

    // scale, offset, numerator, channel, sample, typed,
    // average, level, distance, tens, units, out of range
    directed_blocks = '{
      // reset setting: zero input, full scale, level equal to offset, clamp
      '{330, 13, 2408, 0, 0, 1, 0, 0, 99, 6'h39, 6'h39, 1},
      '{330, 13, 2408, 7, 4095, 1, 4095, 329, 7, 6'h30, 6'h37, 0},
      '{330, 13, 2408, 1, 162, 1, 162, 13, 99, 6'h39, 6'h39, 1},
      '{330, 13, 2408, 2, 174, 0, 0, 0, 0, 0, 0, 0},
      '{330, 13, 2408, 3, 2000, 0, 0, 0, 0, 0, 0, 0},
      // largest scale and numerator, no offset
      '{1023, 0, 65535, 4, 4095, 1, 4095, 1022, 64, 6'h36, 6'h34, 0},
      '{1023, 0, 65535, 5, 8, 0, 0, 0, 0, 0, 0, 0},
      '{1023, 0, 65535, 6, 0, 1, 0, 0, 99, 6'h39, 6'h39, 1},
      // zero scale
      '{0, 0, 0, 0, 4095, 1, 4095, 0, 99, 6'h39, 6'h39, 1},
      // zero numerator, in range and out of range
      '{1023, 0, 0, 1, 4095, 1, 4095, 1022, 0, 6'h30, 6'h30, 0},
      '{1023, 1023, 0, 2, 4095, 0, 0, 0, 0, 0, 0, 0},
      // smallest nonzero scale, largest offset
      '{1, 0, 1, 3, 4095, 0, 0, 0, 0, 0, 0, 0},
      '{1023, 1023, 65535, 4, 2048, 0, 0, 0, 0, 0, 0, 0}
    };

    // reset
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed blocks, sender and receiver both idling
    tx_idle_pct = 26;
    rx_idle_pct = 82;
    foreach (directed_blocks[r]) begin
      row = directed_blocks[r];
      if (row.scale != scale_reg || row.offset != offset_reg || row.numerator != num_reg) begin
        wait_drained();
        apply_setting(row.scale, row.offset, row.numerator);
      end
      if (row.typed) begin
        typed_result[row.channel] = '{row.channel, row.average, row.level, row.distance,
                                      row.tens, row.units, row.oor};
        typed_valid[row.channel]  = 1'b1;
      end
      item.channel = row.channel;
      item.sample  = row.sample;
      repeat (SAMPLES_PER_BLOCK) send_sample(item);
    end

    // random segments, each under its own register setting
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_drained();
      case (seg / 2)
        0: begin
          tx_idle_pct = 26;
          rx_idle_pct = 82;
        end
        1: begin
          tx_idle_pct = 82;
          rx_idle_pct = 26;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      apply_setting(
          LEVEL_W'(($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(150, 1023)),
          LEVEL_W'(($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(40)),
          NUM_W'(($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(200, 6000)));
      if (seg == PRESSURE_SEG) begin
        // long output hold-off while whole blocks keep coming on one channel
        hold_requests++;
        pressure_ch = $urandom_range(NUM_CHANNELS - 1);
        repeat (PRESSURE_BLOCKS * SAMPLES_PER_BLOCK)
          send_sample(next_random_sample(pressure_ch));
      end else begin
        repeat (SEG_SAMPLES)
          send_sample(next_random_sample($urandom_range(NUM_CHANNELS - 1)));
      end
    end

    wait_drained();
    $display("run covered %0d sample transactions and %0d block results", samples_accepted,
             results_checked);
    $display("over %0d register settings, with idling on both sides and a long hold-off",
             settings_applied);
    if (failures == 0) begin
      $display("** channel_average_distance: PASSED **");
    end else begin
      $display("** channel_average_distance: FAILED **");
    end
    $finish;
  end

endmodule
